>>> hdl/ksd_pkg.sv
// Shared types, scancode constants and key map tables for the scancode decoder.
package ksd_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_SCAN  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_FLUSH = 2'd2
   } kind_type;

   // Ring buffer command and status, top level to ring
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_status_type;

   // Set 1 modifier codes
   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_LCTRL_MAKE   = 8'h1D;
   localparam logic [7:0] SC_LCTRL_BREAK  = 8'h9D;

   // ASCII keys that steer the text scale while ctrl is held
   localparam logic [6:0] KEY_ONE        = 7'h31;
   localparam logic [6:0] KEY_FOUR       = 7'h34;
   localparam logic [6:0] KEY_PLUS       = 7'h2B;
   localparam logic [6:0] KEY_EQUALS     = 7'h3D;
   localparam logic [6:0] KEY_MINUS      = 7'h2D;
   localparam logic [6:0] KEY_UNDERSCORE = 7'h5F;

   localparam logic [2:0] SCALE_MIN   = 3'd1;
   localparam logic [2:0] SCALE_MAX   = 3'd4;
   localparam logic [2:0] SCALE_RESET = 3'd2;

   function automatic logic [6:0] map_plain(input logic [6:0] code);
      logic [6:0] key;
      unique case (code)
         7'd1:  key = 7'h1B;
         7'd2:  key = 7'h31;
         7'd3:  key = 7'h32;
         7'd4:  key = 7'h33;
         7'd5:  key = 7'h34;
         7'd6:  key = 7'h35;
         7'd7:  key = 7'h36;
         7'd8:  key = 7'h37;
         7'd9:  key = 7'h38;
         7'd10: key = 7'h39;
         7'd11: key = 7'h30;
         7'd12: key = 7'h2D;
         7'd13: key = 7'h3D;
         7'd14: key = 7'h08;
         7'd15: key = 7'h09;
         7'd16: key = 7'h71;
         7'd17: key = 7'h77;
         7'd18: key = 7'h65;
         7'd19: key = 7'h72;
         7'd20: key = 7'h74;
         7'd21: key = 7'h79;
         7'd22: key = 7'h75;
         7'd23: key = 7'h69;
         7'd24: key = 7'h6F;
         7'd25: key = 7'h70;
         7'd26: key = 7'h5B;
         7'd27: key = 7'h5D;
         7'd28: key = 7'h0A;
         7'd30: key = 7'h61;
         7'd31: key = 7'h73;
         7'd32: key = 7'h64;
         7'd33: key = 7'h66;
         7'd34: key = 7'h67;
         7'd35: key = 7'h68;
         7'd36: key = 7'h6A;
         7'd37: key = 7'h6B;
         7'd38: key = 7'h6C;
         7'd39: key = 7'h3B;
         7'd40: key = 7'h27;
         7'd41: key = 7'h60;
         7'd43: key = 7'h5C;
         7'd44: key = 7'h7A;
         7'd45: key = 7'h78;
         7'd46: key = 7'h63;
         7'd47: key = 7'h76;
         7'd48: key = 7'h62;
         7'd49: key = 7'h6E;
         7'd50: key = 7'h6D;
         7'd51: key = 7'h2C;
         7'd52: key = 7'h2E;
         7'd53: key = 7'h2F;
         7'd55: key = 7'h2A;
         7'd57: key = 7'h20;
         default: key = 7'h00;
      endcase
      return key;
   endfunction

   function automatic logic [6:0] map_shifted(input logic [6:0] code);
      logic [6:0] key;
      unique case (code)
         7'd1:  key = 7'h1B;
         7'd2:  key = 7'h21;
         7'd3:  key = 7'h40;
         7'd4:  key = 7'h23;
         7'd5:  key = 7'h24;
         7'd6:  key = 7'h25;
         7'd7:  key = 7'h5E;
         7'd8:  key = 7'h26;
         7'd9:  key = 7'h2A;
         7'd10: key = 7'h28;
         7'd11: key = 7'h29;
         7'd12: key = 7'h5F;
         7'd13: key = 7'h2B;
         7'd14: key = 7'h08;
         7'd15: key = 7'h09;
         7'd16: key = 7'h51;
         7'd17: key = 7'h57;
         7'd18: key = 7'h45;
         7'd19: key = 7'h52;
         7'd20: key = 7'h54;
         7'd21: key = 7'h59;
         7'd22: key = 7'h55;
         7'd23: key = 7'h49;
         7'd24: key = 7'h4F;
         7'd25: key = 7'h50;
         7'd26: key = 7'h7B;
         7'd27: key = 7'h7D;
         7'd28: key = 7'h0A;
         7'd30: key = 7'h41;
         7'd31: key = 7'h53;
         7'd32: key = 7'h44;
         7'd33: key = 7'h46;
         7'd34: key = 7'h47;
         7'd35: key = 7'h48;
         7'd36: key = 7'h4A;
         7'd37: key = 7'h4B;
         7'd38: key = 7'h4C;
         7'd39: key = 7'h3A;
         7'd40: key = 7'h22;
         7'd41: key = 7'h7E;
         7'd43: key = 7'h7C;
         7'd44: key = 7'h5A;
         7'd45: key = 7'h58;
         7'd46: key = 7'h43;
         7'd47: key = 7'h56;
         7'd48: key = 7'h42;
         7'd49: key = 7'h4E;
         7'd50: key = 7'h4D;
         7'd51: key = 7'h3C;
         7'd52: key = 7'h3E;
         7'd53: key = 7'h3F;
         7'd55: key = 7'h2A;
         7'd57: key = 7'h20;
         default: key = 7'h00;
      endcase
      return key;
   endfunction

endpackage

>>> hdl/ksd_ring.sv
// Raw byte ring buffer: pointers and a synchronous byte memory with registered read data.
module ksd_ring #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ksd_pkg::ring_cmd_type    cmd,
   input  logic [7:0]               wr_data,
   output ksd_pkg::ring_status_type status,
   output logic [7:0]               rd_data
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [7:0]       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next, rd_ptr_next;
   logic [7:0]       rd_data_ff;

   assign wr_ptr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   // One slot stays free, so full means the write pointer is one behind the read pointer
   assign status.full  = (wr_ptr_next == rd_ptr_ff);
   assign status.empty = (wr_ptr_ff == rd_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (cmd.push) begin
         wr_ptr_in = wr_ptr_next;
      end
      if (cmd.pop) begin
         rd_ptr_in = rd_ptr_next;
      end else if (cmd.flush) begin
         rd_ptr_in = wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // One command per cycle: a push lands before any later pop reads the same slot
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   // Read data holds until the next pop
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/keyboard_scancode_decoder_fifo.sv
// Top level: set 1 scancode decoder with modifier tracking, text scale and raw byte ring buffer.
//
// Takes one item per cycle on the req_ channel while req_stall is low and returns exactly one
// result per item on the rsp_ channel via the S1 and S2 registers. Every scancode item offers
// its byte to a ring of FIFO_DEPTH entries that holds at most FIFO_DEPTH-1 bytes; a byte that
// finds it full is reported as dropped but still decoded. Read items pop the oldest byte from
// the ring memory, whose read port is registered; flush items empty the ring. The pointers,
// modifier flags and scale update in the transfer cycle, so the next item can follow at once.
// A result register plus a holding stage let one more item in while a result waits under
// rsp_stall. The byte memory is not cleared after reset; it is only read once written. The user
// must write csr_write_data (shell enable) only while the block is idle; it is not enforced.
module keyboard_scancode_decoder_fifo #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_scancode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_char_valid,
   output logic [6:0] rsp_char_code,
   output logic [2:0] rsp_scale_now,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_shift_held,
   output logic       rsp_ctrl_held,
   output logic       rsp_dropped
);

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
      logic [2:0] scale_now;
      logic       read_valid;
      logic       shift_held;
      logic       ctrl_held;
      logic       dropped;
   } result_type;

   ksd_pkg::kind_type        kind;
   ksd_pkg::ring_cmd_type    ring_cmd;
   ksd_pkg::ring_status_type ring_status;
   logic [7:0]               ring_rd_data;

   logic       shell_enable_ff;
   logic       shift_ff, shift_in;
   logic       ctrl_ff, ctrl_in;
   logic [2:0] scale_ff, scale_in;

   logic       accept;
   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       s2_free, s1_move;
   result_type s1_ff, s1_in;
   result_type s2_ff;
   logic [7:0] s2_read_byte_ff;

   logic [6:0] key;
   logic       char_valid;
   logic [6:0] char_code;

   assign kind = ksd_pkg::kind_type'(req_kind);

   // Handshake: S1 holds a fresh result, S2 is the output register
   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign accept    = req_valid && !req_stall;

   assign key = shift_ff ? ksd_pkg::map_shifted(req_scancode[6:0])
                         : ksd_pkg::map_plain(req_scancode[6:0]);

   always_comb begin
      ring_cmd   = '0;
      shift_in   = shift_ff;
      ctrl_in    = ctrl_ff;
      scale_in   = scale_ff;
      char_valid = 1'b0;
      char_code  = '0;
      if (accept) begin
         unique case (kind)
            ksd_pkg::KIND_SCAN: begin
               ring_cmd.push = !ring_status.full;
               unique case (req_scancode) inside
                  ksd_pkg::SC_LSHIFT_MAKE, ksd_pkg::SC_RSHIFT_MAKE:   shift_in = 1'b1;
                  ksd_pkg::SC_LSHIFT_BREAK, ksd_pkg::SC_RSHIFT_BREAK: shift_in = 1'b0;
                  ksd_pkg::SC_LCTRL_MAKE:                             ctrl_in  = 1'b1;
                  ksd_pkg::SC_LCTRL_BREAK:                            ctrl_in  = 1'b0;
                  default: begin
                     // Make codes only; other releases just go to the ring
                     if (!req_scancode[7]) begin
                        if (ctrl_ff) begin
                           unique case (key) inside
                              [ksd_pkg::KEY_ONE:ksd_pkg::KEY_FOUR]: begin
                                 // ASCII digits 1 to 4 carry the scale in their low bits
                                 scale_in = key[2:0];
                              end
                              ksd_pkg::KEY_PLUS, ksd_pkg::KEY_EQUALS: begin
                                 if (scale_ff < ksd_pkg::SCALE_MAX) begin
                                    scale_in = scale_ff + 3'd1;
                                 end
                              end
                              ksd_pkg::KEY_MINUS, ksd_pkg::KEY_UNDERSCORE: begin
                                 if (scale_ff > ksd_pkg::SCALE_MIN) begin
                                    scale_in = scale_ff - 3'd1;
                                 end
                              end
                              default: ;
                           endcase
                        end else if (key != 7'h00 && shell_enable_ff) begin
                           char_valid = 1'b1;
                           char_code  = key;
                        end
                     end
                  end
               endcase
            end
            ksd_pkg::KIND_READ:  ring_cmd.pop   = !ring_status.empty;
            ksd_pkg::KIND_FLUSH: ring_cmd.flush = 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_in.char_valid = char_valid;
      s1_in.char_code  = char_code;
      s1_in.scale_now  = scale_in;
      s1_in.read_valid = ring_cmd.pop;
      s1_in.shift_held = shift_in;
      s1_in.ctrl_held  = ctrl_in;
      s1_in.dropped    = accept && (kind == ksd_pkg::KIND_SCAN) && ring_status.full;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_free) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shell_enable_ff <= 1'b0;
         shift_ff        <= 1'b0;
         ctrl_ff         <= 1'b0;
         scale_ff        <= ksd_pkg::SCALE_RESET;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            shell_enable_ff <= csr_write_data;
         end
         shift_ff    <= shift_in;
         ctrl_ff     <= ctrl_in;
         scale_ff    <= scale_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         s2_ff           <= s1_ff;
         s2_read_byte_ff <= s1_ff.read_valid ? ring_rd_data : 8'h00;
      end
   end

   ksd_ring #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .wr_data (req_scancode),
      .status  (ring_status),
      .rd_data (ring_rd_data)
   );

   assign rsp_valid      = s2_valid_ff;
   assign rsp_char_valid = s2_ff.char_valid;
   assign rsp_char_code  = s2_ff.char_code;
   assign rsp_scale_now  = s2_ff.scale_now;
   assign rsp_read_valid = s2_ff.read_valid;
   assign rsp_read_byte  = s2_read_byte_ff;
   assign rsp_shift_held = s2_ff.shift_held;
   assign rsp_ctrl_held  = s2_ff.ctrl_held;
   assign rsp_dropped    = s2_ff.dropped;

`ifndef SYNTHESIS
   // A flush leaves the ring empty
   assert property (@(posedge clock) disable iff (reset)
      ring_cmd.flush |=> ring_status.empty)
      else $error("ring not empty after flush");

   // A push leaves at least one byte behind
   assert property (@(posedge clock) disable iff (reset)
      ring_cmd.push |=> !ring_status.empty)
      else $error("ring empty after push");

   // A pop frees a slot
   assert property (@(posedge clock) disable iff (reset)
      ring_cmd.pop |=> !ring_status.full)
      else $error("ring full after pop");

   // A blocked result in S1 stays put
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_free) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("held result lost");

   // Scale stays within its range
   assert property (@(posedge clock) disable iff (reset)
      (scale_ff >= ksd_pkg::SCALE_MIN) && (scale_ff <= ksd_pkg::SCALE_MAX))
      else $error("scale out of range");
`endif

endmodule
